/* rtl/core/assert_macros.svh */
// assertion helpers shared by the core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// condition that must never hold at a clock edge
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

/* rtl/core/pcc_pkg.sv */
package pcc_pkg;

	localparam int ISO_W   = 26;   // raw iso * 1000, max 65,535,000
	localparam int NSL_W   = 22;   // pt * 40
	localparam int PSL_W   = 19;   // pt * 5
	localparam int PADDR_W = 3;

	localparam logic REG_BARREL_MODE = 1'b0;

	localparam logic [15:0] PT_MIN_TENTH   = 16'd150;
	localparam logic [13:0] BARREL_ETA_MAX = 14'd1479;
	localparam logic [13:0] ENDCAP_ETA_MIN = 14'd1500;
	localparam logic [13:0] ENDCAP_ETA_MAX = 14'd3000;
	localparam logic [11:0] HOE_MAX_MILLI  = 12'd50;

	// shower width cuts
	localparam logic [13:0] EB_L_SW = 14'd120;
	localparam logic [13:0] EB_M_SW = 14'd110;
	localparam logic [13:0] EE_L_SW = 14'd340;
	localparam logic [13:0] EE_M_SW = 14'd330;
	localparam logic [13:0] EE_T_SW = 14'd310;

	// isolation cuts, units of 1e-4 GeV
	localparam logic [ISO_W-1:0] EB_L_CH = 26'd26000;
	localparam logic [ISO_W-1:0] EB_M_CH = 26'd15000;
	localparam logic [ISO_W-1:0] EB_T_CH = 26'd7000;
	localparam logic [ISO_W-1:0] EB_L_NE = 26'd35000;
	localparam logic [ISO_W-1:0] EB_M_NE = 26'd10000;
	localparam logic [ISO_W-1:0] EB_T_NE = 26'd4000;
	localparam logic [ISO_W-1:0] EB_L_PH = 26'd13000;
	localparam logic [ISO_W-1:0] EB_M_PH = 26'd7000;
	localparam logic [ISO_W-1:0] EB_T_PH = 26'd5000;
	localparam logic [ISO_W-1:0] EE_L_CH = 26'd23000;
	localparam logic [ISO_W-1:0] EE_M_CH = 26'd12000;
	localparam logic [ISO_W-1:0] EE_T_CH = 26'd5000;
	localparam logic [ISO_W-1:0] EE_L_NE = 26'd29000;
	localparam logic [ISO_W-1:0] EE_M_NE = 26'd15000;
	localparam logic [ISO_W-1:0] EE_T_NE = 26'd15000;
	localparam logic [ISO_W-1:0] EE_M_PH = 26'd10000;
	localparam logic [ISO_W-1:0] EE_T_PH = 26'd10000;

	typedef struct packed {
		logic [15:0]        pt_tenth_gev;
		logic signed [13:0] eta_milli;
		logic [13:0]        shower_width;
		logic [11:0]        had_over_em_milli;
		logic               prompt_electron_match;
		logic [15:0]        charged_iso;
		logic [15:0]        neutral_iso;
		logic [15:0]        photon_iso_raw;
		logic [9:0]         rho_tenth_gev;
	} cand_t;

	typedef struct packed {
		logic [4:0] ch;
		logic [6:0] ne;
		logic [8:0] ph;
	} area_t;

	typedef struct packed {
		logic             acc;
		logic             barrel;
		logic             base;
		logic [13:0]      sw;
		logic [ISO_W-1:0] ch;
		logic [ISO_W-1:0] ne;
		logic [ISO_W-1:0] ph;
		logic [NSL_W-1:0] nslope;
		logic [PSL_W-1:0] pslope;
	} corr_t;

	typedef struct packed {
		logic acc;
		logic loose;
		logic med;
		logic tight;
	} flags_t;

	// effective areas in 0.001 units; exact bin edges get zero
	function automatic area_t pick_area(input logic [13:0] a);
		area_t r;
		r = '0;
		if (a < 14'd1000) begin
			r = '{ch: 5'd12, ne: 7'd30, ph: 9'd148};
		end else if (a > 14'd1000 && a < 14'd1479) begin
			r = '{ch: 5'd10, ne: 7'd57, ph: 9'd130};
		end else if (a > 14'd1479 && a < 14'd2000) begin
			r = '{ch: 5'd14, ne: 7'd39, ph: 9'd112};
		end else if (a > 14'd2000 && a < 14'd2200) begin
			r = '{ch: 5'd12, ne: 7'd15, ph: 9'd216};
		end else if (a > 14'd2200 && a < 14'd2300) begin
			r = '{ch: 5'd16, ne: 7'd24, ph: 9'd262};
		end else if (a > 14'd2300 && a < 14'd2400) begin
			r = '{ch: 5'd20, ne: 7'd39, ph: 9'd260};
		end else if (a > 14'd2400) begin
			r = '{ch: 5'd12, ne: 7'd72, ph: 9'd266};
		end
		return r;
	endfunction

endpackage

/* rtl/core/pcc_if.sv */
interface pcc_cand_if;
	logic               valid;
	logic               ready;
	logic [15:0]        pt_tenth_gev;
	logic signed [13:0] eta_milli;
	logic [13:0]        shower_width;
	logic [11:0]        had_over_em_milli;
	logic               prompt_electron_match;
	logic [15:0]        charged_iso;
	logic [15:0]        neutral_iso;
	logic [15:0]        photon_iso_raw;
	logic [9:0]         rho_tenth_gev;

	modport source (
		output valid, pt_tenth_gev, eta_milli, shower_width, had_over_em_milli,
			prompt_electron_match, charged_iso, neutral_iso, photon_iso_raw,
			rho_tenth_gev,
		input  ready
	);
	modport sink (
		input  valid, pt_tenth_gev, eta_milli, shower_width, had_over_em_milli,
			prompt_electron_match, charged_iso, neutral_iso, photon_iso_raw,
			rho_tenth_gev,
		output ready
	);
endinterface

interface pcc_result_if;
	logic valid;
	logic ready;
	logic in_acceptance;
	logic pass_loose;
	logic pass_medium;
	logic pass_tight;

	modport source (
		output valid, in_acceptance, pass_loose, pass_medium, pass_tight,
		input  ready
	);
	modport sink (
		input  valid, in_acceptance, pass_loose, pass_medium, pass_tight,
		output ready
	);
endinterface

/* rtl/core/photon_id_cut_classifier_core.sv */
// Throughput: one candidate per cycle while result.ready stays high; three registered
// stages (input, pileup correction, cut evaluation) each move on independently when
// the next one frees up.
// Reset (arst_n low, asynchronous): all stages empty, barrel_mode = 1.
`include "assert_macros.svh"

module photon_id_cut_classifier_core (
	input  logic                        clk,
	input  logic                        arst_n,
	pcc_cand_if.sink                    cand,
	pcc_result_if.source                result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pcc_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	logic            barrel_mode;
	logic            v_s1, v_s2, res_v_q;
	pcc_pkg::cand_t  cand_s1, cand_w;
	pcc_pkg::corr_t  corr_w, corr_s2;
	pcc_pkg::flags_t flags_w, res_q;
	logic            en_s1, en_s2, en_out;

	pcc_apb_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.barrel_mode (barrel_mode)
	);

	// bubbles collapse: a stage loads whenever it is empty or its word moves on
	assign en_out = result.ready || !res_v_q;
	assign en_s2  = !v_s2 || en_out;
	assign en_s1  = !v_s1 || en_s2;
	assign cand.ready = en_s1;

	always_comb begin
		cand_w.pt_tenth_gev          = cand.pt_tenth_gev;
		cand_w.eta_milli             = cand.eta_milli;
		cand_w.shower_width          = cand.shower_width;
		cand_w.had_over_em_milli     = cand.had_over_em_milli;
		cand_w.prompt_electron_match = cand.prompt_electron_match;
		cand_w.charged_iso           = cand.charged_iso;
		cand_w.neutral_iso           = cand.neutral_iso;
		cand_w.photon_iso_raw        = cand.photon_iso_raw;
		cand_w.rho_tenth_gev         = cand.rho_tenth_gev;
	end

	pcc_area_corr u_corr (
		.cand   (cand_s1),
		.barrel (barrel_mode),
		.corr   (corr_w)
	);

	pcc_cut_eval u_cuts (
		.corr  (corr_s2),
		.flags (flags_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= cand.valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_out) begin
				res_v_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			cand_s1 <= cand_w;
		end
		if (en_s2) begin
			corr_s2 <= corr_w;
		end
		if (en_out) begin
			res_q <= flags_w;
		end
	end

	assign result.valid         = res_v_q;
	assign result.in_acceptance = res_q.acc;
	assign result.pass_loose    = res_q.loose;
	assign result.pass_medium   = res_q.med;
	assign result.pass_tight    = res_q.tight;

	`ASSERT_CLK(a_s1_hold, clk, arst_n, v_s1 && !en_s2 |=> v_s1 && $stable(cand_s1), "stalled s1 word changed")
	`ASSERT_CLK(a_s2_hold, clk, arst_n, v_s2 && !en_out |=> v_s2 && $stable(corr_s2), "stalled s2 word changed")
	`ASSERT_NEVER(a_nested, clk, arst_n, res_v_q && ((res_q.tight && !res_q.med) || (res_q.med && !res_q.loose) || (res_q.loose && !res_q.acc)), "flags not nested")

endmodule

/* rtl/core/pcc_apb_regs.sv */
module pcc_apb_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pcc_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic                        barrel_mode
);

	logic barrel_mode_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == pcc_pkg::REG_BARREL_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			barrel_mode_q <= 1'b1;
		end else if (wr_en) begin
			barrel_mode_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == pcc_pkg::REG_BARREL_MODE) begin
			prdata = {31'd0, barrel_mode_q};
		end
	end

	assign barrel_mode = barrel_mode_q;

endmodule

/* rtl/core/pcc_area_corr.sv */
module pcc_area_corr (
	input  pcc_pkg::cand_t cand,
	input  logic           barrel,
	output pcc_pkg::corr_t corr
);

	logic [13:0]               abs_eta;
	logic                      region_ok;
	pcc_pkg::area_t            area;
	logic [pcc_pkg::ISO_W-1:0] ch_c, ne_c, ph_c;

	// scale raw iso by 1000, subtract rho * area, floor at zero
	function automatic logic [pcc_pkg::ISO_W-1:0] corr_iso(
		input logic [15:0] raw,
		input logic [9:0]  rho,
		input logic [8:0]  ea
	);
		logic [pcc_pkg::ISO_W-1:0] scaled;
		logic [18:0]               pu;
		scaled = (pcc_pkg::ISO_W'(raw) << 10) - (pcc_pkg::ISO_W'(raw) << 4)
			- (pcc_pkg::ISO_W'(raw) << 3);
		pu     = 19'(rho) * 19'(ea);
		return (scaled < pcc_pkg::ISO_W'(pu)) ? '0 : scaled - pcc_pkg::ISO_W'(pu);
	endfunction

	// 14-bit wrap handles the most negative code as +8192
	assign abs_eta = cand.eta_milli[13] ? 14'(14'd0 - cand.eta_milli) : cand.eta_milli;

	assign region_ok = barrel ? (abs_eta <= pcc_pkg::BARREL_ETA_MAX)
		: (abs_eta >= pcc_pkg::ENDCAP_ETA_MIN && abs_eta <= pcc_pkg::ENDCAP_ETA_MAX);

	assign area = pcc_pkg::pick_area(abs_eta);

	assign ch_c = corr_iso(cand.charged_iso, cand.rho_tenth_gev, 9'(area.ch));
	assign ne_c = corr_iso(cand.neutral_iso, cand.rho_tenth_gev, 9'(area.ne));
	assign ph_c = corr_iso(cand.photon_iso_raw, cand.rho_tenth_gev, area.ph);

	always_comb begin
		corr.acc    = (cand.pt_tenth_gev >= pcc_pkg::PT_MIN_TENTH) && region_ok;
		corr.barrel = barrel;
		corr.base   = !cand.prompt_electron_match
			&& (cand.had_over_em_milli < pcc_pkg::HOE_MAX_MILLI);
		corr.sw     = cand.shower_width;
		corr.ch     = ch_c;
		corr.ne     = ne_c;
		corr.ph     = ph_c;
		corr.nslope = (pcc_pkg::NSL_W'(cand.pt_tenth_gev) << 5)
			+ (pcc_pkg::NSL_W'(cand.pt_tenth_gev) << 3);
		corr.pslope = (pcc_pkg::PSL_W'(cand.pt_tenth_gev) << 2)
			+ pcc_pkg::PSL_W'(cand.pt_tenth_gev);
	end

endmodule

/* rtl/core/pcc_cut_eval.sv */
module pcc_cut_eval (
	input  pcc_pkg::corr_t  corr,
	output pcc_pkg::flags_t flags
);

	logic [pcc_pkg::ISO_W-1:0] ns, ps;
	logic eb_l, eb_m, eb_t, ee_l, ee_m, ee_t;

	assign ns = pcc_pkg::ISO_W'(corr.nslope);
	assign ps = pcc_pkg::ISO_W'(corr.pslope);

	assign eb_l = corr.base && corr.sw < pcc_pkg::EB_L_SW && corr.ch < pcc_pkg::EB_L_CH
		&& corr.ne < pcc_pkg::EB_L_NE + ns && corr.ph < pcc_pkg::EB_L_PH + ps;
	assign eb_m = eb_l && corr.sw < pcc_pkg::EB_M_SW && corr.ch < pcc_pkg::EB_M_CH
		&& corr.ne < pcc_pkg::EB_M_NE + ns && corr.ph < pcc_pkg::EB_M_PH + ps;
	assign eb_t = eb_m && corr.ch < pcc_pkg::EB_T_CH
		&& corr.ne < pcc_pkg::EB_T_NE + ns && corr.ph < pcc_pkg::EB_T_PH + ps;

	// endcap loose carries no photon iso cut
	assign ee_l = corr.base && corr.sw < pcc_pkg::EE_L_SW && corr.ch < pcc_pkg::EE_L_CH
		&& corr.ne < pcc_pkg::EE_L_NE + ns;
	assign ee_m = ee_l && corr.sw < pcc_pkg::EE_M_SW && corr.ch < pcc_pkg::EE_M_CH
		&& corr.ne < pcc_pkg::EE_M_NE + ns && corr.ph < pcc_pkg::EE_M_PH + ps;
	assign ee_t = ee_m && corr.sw < pcc_pkg::EE_T_SW && corr.ch < pcc_pkg::EE_T_CH
		&& corr.ne < pcc_pkg::EE_T_NE + ns && corr.ph < pcc_pkg::EE_T_PH + ps;

	always_comb begin
		flags.acc   = corr.acc;
		flags.loose = corr.acc && (corr.barrel ? eb_l : ee_l);
		flags.med   = corr.acc && (corr.barrel ? eb_m : ee_m);
		flags.tight = corr.acc && (corr.barrel ? eb_t : ee_t);
	end

endmodule

/* bench/tb_photon_id_cut_classifier_core.sv */
`timescale 1ns / 1ps

module tb_photon_id_cut_classifier_core;

	localparam int LIMIT_CYCLES = 400000;
	localparam int LONG_HOLD    = 200;
	localparam logic [pcc_pkg::PADDR_W-1:0] BARREL_ADDR = {pcc_pkg::REG_BARREL_MODE, 2'b00};
	// register index 1 does not exist, writes there must be dropped
	localparam logic [pcc_pkg::PADDR_W-1:0] SPARE_ADDR = 3'd4;

	class photon_flag_scoreboard;
		bit barrel_mode = 1'b1;
		pcc_pkg::flags_t expected_flags[$];
		int errors;
		int results_seen;

		function longint pu_subtract(longint raw, longint rho, longint area);
			longint v;
			v = raw * 1000 - rho * area;
			return (v < 0) ? 0 : v;
		endfunction

		function pcc_pkg::flags_t classify_photon(pcc_pkg::cand_t c);
			pcc_pkg::flags_t f;
			int e;
			int a;
			longint pt, rho, ch, ne, ph, nsl, psl;
			longint ea_ch, ea_ne, ea_ph;
			bit acc, base, l, m, t;
			e = $signed(c.eta_milli);
			a = (e < 0) ? -e : e;
			pt = longint'(c.pt_tenth_gev);
			rho = longint'(c.rho_tenth_gev);
			l = 0;
			m = 0;
			t = 0;
			acc = pt >= 150 && (barrel_mode ? (a <= 1479) : (a >= 1500 && a <= 3000));
			if (acc) begin
				// exact bin edges keep zero area
				ea_ch = 0;
				ea_ne = 0;
				ea_ph = 0;
				if (a < 1000) begin
					ea_ch = 12; ea_ne = 30; ea_ph = 148;
				end else if (a > 1000 && a < 1479) begin
					ea_ch = 10; ea_ne = 57; ea_ph = 130;
				end else if (a > 1479 && a < 2000) begin
					ea_ch = 14; ea_ne = 39; ea_ph = 112;
				end else if (a > 2000 && a < 2200) begin
					ea_ch = 12; ea_ne = 15; ea_ph = 216;
				end else if (a > 2200 && a < 2300) begin
					ea_ch = 16; ea_ne = 24; ea_ph = 262;
				end else if (a > 2300 && a < 2400) begin
					ea_ch = 20; ea_ne = 39; ea_ph = 260;
				end else if (a > 2400) begin
					ea_ch = 12; ea_ne = 72; ea_ph = 266;
				end
				ch = pu_subtract(longint'(c.charged_iso), rho, ea_ch);
				ne = pu_subtract(longint'(c.neutral_iso), rho, ea_ne);
				ph = pu_subtract(longint'(c.photon_iso_raw), rho, ea_ph);
				nsl = 40 * pt;
				psl = 5 * pt;
				base = !c.prompt_electron_match && c.had_over_em_milli < 50;
				if (barrel_mode) begin
					l = base && c.shower_width < 120 && ch < 26000 &&
						ne < 35000 + nsl && ph < 13000 + psl;
					m = l && c.shower_width < 110 && ch < 15000 &&
						ne < 10000 + nsl && ph < 7000 + psl;
					t = m && ch < 7000 && ne < 4000 + nsl && ph < 5000 + psl;
				end else begin
					// no photon iso cut at loose in the endcap
					l = base && c.shower_width < 340 && ch < 23000 && ne < 29000 + nsl;
					m = l && c.shower_width < 330 && ch < 12000 &&
						ne < 15000 + nsl && ph < 10000 + psl;
					t = m && c.shower_width < 310 && ch < 5000 &&
						ne < 15000 + nsl && ph < 10000 + psl;
				end
			end
			f.acc = acc;
			f.loose = l;
			f.med = m;
			f.tight = t;
			return f;
		endfunction

		function void note_candidate(pcc_pkg::cand_t c);
			expected_flags.push_back(classify_photon(c));
		endfunction

		function int pending();
			return expected_flags.size();
		endfunction

		task report(string msg);
			$display("ERROR result word %0d: %s", results_seen, msg);
			errors++;
		endtask

		task check_result(pcc_pkg::flags_t got);
			pcc_pkg::flags_t want;
			string names[4] = '{"pass_tight", "pass_medium", "pass_loose", "in_acceptance"};
			results_seen++;
			if (expected_flags.size() == 0) begin
				report("result word with nothing expected");
				return;
			end
			want = expected_flags.pop_front();
			for (int i = 0; i < 4; i++) begin
				if (got[i] !== want[i])
					report($sformatf("%s expected %0b got %0b", names[i], want[i], got[i]));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [pcc_pkg::PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	pcc_cand_if   cand_if();
	pcc_result_if res_if();

	photon_flag_scoreboard sb = new();
	bit hold_req;
	int cycles;
	int eta_edges[6] = '{1000, 1479, 2000, 2200, 2300, 2400};

	photon_id_cut_classifier_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cand    (cand_if),
		.result  (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// mostly a narrow range near the cuts, sometimes the full field width
	function automatic int unsigned pick(int unsigned narrow_hi, int w);
		if ($urandom_range(0, 9) == 0)
			return $urandom & ((32'd1 << w) - 1);
		return $urandom_range(0, narrow_hi);
	endfunction

	function automatic pcc_pkg::cand_t random_cand(bit barrel);
		pcc_pkg::cand_t c;
		int r;
		int a;
		r = $urandom_range(0, 99);
		if (r < 80)
			a = barrel ? $urandom_range(0, 1479) : $urandom_range(1500, 3000);
		else if (r < 90)
			a = eta_edges[$urandom_range(0, 5)];
		else
			a = $urandom_range(0, 8192);
		c.eta_milli = 14'($urandom_range(0, 1) ? -a : a);
		c.pt_tenth_gev = 16'(pick(2500, 16));
		c.shower_width = 14'(pick(barrel ? 160 : 400, 14));
		c.had_over_em_milli = 12'(pick(70, 12));
		c.prompt_electron_match = ($urandom_range(0, 9) == 0);
		c.charged_iso = 16'(pick(40, 16));
		c.neutral_iso = 16'(pick(60 + c.pt_tenth_gev / 20, 16));
		c.photon_iso_raw = 16'(pick(60, 16));
		c.rho_tenth_gev = 10'(pick(400, 10));
		return c;
	endfunction

	function automatic pcc_pkg::cand_t nominal(bit barrel);
		pcc_pkg::cand_t c;
		c = '0;
		c.pt_tenth_gev = 300;
		c.eta_milli = barrel ? 500 : 2100;
		c.shower_width = barrel ? 80 : 200;
		c.had_over_em_milli = 10;
		return c;
	endfunction

	task automatic send_cand(input pcc_pkg::cand_t c, input bit may_idle);
		if (may_idle && $urandom_range(0, 99) < 35) begin
			cand_if.valid <= 1'b0;
			repeat (idle_len()) @(posedge clk);
		end
		cand_if.valid <= 1'b1;
		cand_if.pt_tenth_gev <= c.pt_tenth_gev;
		cand_if.eta_milli <= c.eta_milli;
		cand_if.shower_width <= c.shower_width;
		cand_if.had_over_em_milli <= c.had_over_em_milli;
		cand_if.prompt_electron_match <= c.prompt_electron_match;
		cand_if.charged_iso <= c.charged_iso;
		cand_if.neutral_iso <= c.neutral_iso;
		cand_if.photon_iso_raw <= c.photon_iso_raw;
		cand_if.rho_tenth_gev <= c.rho_tenth_gev;
		@(posedge clk);
		while (cand_if.ready !== 1'b1) @(posedge clk);
	endtask

	task automatic apb_write(input logic [pcc_pkg::PADDR_W-1:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == BARREL_ADDR)
			sb.barrel_mode = data[0];
	endtask

	task automatic drain();
		cand_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_directed(input bit barrel);
		pcc_pkg::cand_t c;
		if (barrel) begin
			send_cand(nominal(1), 1);
			send_cand('0, 1);
			send_cand('1, 1);
			c = nominal(1); c.pt_tenth_gev = 149; send_cand(c, 1);
			c = nominal(1); c.pt_tenth_gev = 150; send_cand(c, 1);
			// edge eta: no pileup subtraction, so charged iso fails tight only
			c = nominal(1); c.eta_milli = -1479; c.rho_tenth_gev = 1023;
			c.charged_iso = 10; send_cand(c, 1);
			c = nominal(1); c.eta_milli = -1480; send_cand(c, 1);
			c = nominal(1); c.eta_milli = 1000; c.rho_tenth_gev = 1023;
			c.charged_iso = 10; send_cand(c, 1);
			c = nominal(1); c.had_over_em_milli = 49; send_cand(c, 1);
			c = nominal(1); c.had_over_em_milli = 50; send_cand(c, 1);
			c = nominal(1); c.prompt_electron_match = 1'b1; send_cand(c, 1);
			c = nominal(1); c.eta_milli = 14'h2000; send_cand(c, 1);
		end else begin
			send_cand(nominal(0), 1);
			c = nominal(0); c.eta_milli = 1499; send_cand(c, 1);
			c = nominal(0); c.eta_milli = 1500; send_cand(c, 1);
			c = nominal(0); c.eta_milli = -3000; send_cand(c, 1);
			c = nominal(0); c.eta_milli = 3001; send_cand(c, 1);
			for (int i = 2; i < 6; i++) begin
				c = nominal(0);
				c.eta_milli = 14'((i % 2) ? -eta_edges[i] : eta_edges[i]);
				c.rho_tenth_gev = 1023;
				c.charged_iso = 10;
				send_cand(c, 1);
			end
			c = nominal(0); c.photon_iso_raw = 16'hffff; send_cand(c, 1);
			c = nominal(0); c.shower_width = 339; send_cand(c, 1);
		end
	endtask

	task automatic run_random(input int n, input bit pressure);
		for (int i = 0; i < n; i++) begin
			// long sink hold-off while the source keeps pushing
			if (pressure && i == 30)
				hold_req = 1'b1;
			send_cand(random_cand(sb.barrel_mode), !(pressure && i >= 30 && i < 70));
		end
	endtask

	initial begin : result_sink
		res_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				res_if.ready <= 1'b0;
				for (int n = 0; n < LONG_HOLD; n++) @(posedge clk);
			end else begin
				res_if.ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
				if ($urandom_range(0, 99) < 60) begin
					res_if.ready <= 1'b0;
					repeat (idle_len()) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin : monitors
		pcc_pkg::cand_t w;
		pcc_pkg::flags_t r;
		if (arst_n && cand_if.valid && cand_if.ready) begin
			w.pt_tenth_gev = cand_if.pt_tenth_gev;
			w.eta_milli = cand_if.eta_milli;
			w.shower_width = cand_if.shower_width;
			w.had_over_em_milli = cand_if.had_over_em_milli;
			w.prompt_electron_match = cand_if.prompt_electron_match;
			w.charged_iso = cand_if.charged_iso;
			w.neutral_iso = cand_if.neutral_iso;
			w.photon_iso_raw = cand_if.photon_iso_raw;
			w.rho_tenth_gev = cand_if.rho_tenth_gev;
			sb.note_candidate(w);
		end
		if (arst_n && res_if.valid && res_if.ready) begin
			r.acc = res_if.in_acceptance;
			r.loose = res_if.pass_loose;
			r.med = res_if.pass_medium;
			r.tight = res_if.pass_tight;
			sb.check_result(r);
		end
	end

	initial begin : watchdog
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		hold_req = 1'b0;
		cand_if.valid = 1'b0;
		cand_if.pt_tenth_gev = '0;
		cand_if.eta_milli = '0;
		cand_if.shower_width = '0;
		cand_if.had_over_em_milli = '0;
		cand_if.prompt_electron_match = 1'b0;
		cand_if.charged_iso = '0;
		cand_if.neutral_iso = '0;
		cand_if.photon_iso_raw = '0;
		cand_if.rho_tenth_gev = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// barrel from reset
		run_directed(1);
		run_random(100, 1);
		drain();

		apb_write(BARREL_ADDR, 32'd0);
		run_directed(0);
		run_random(100, 0);
		drain();

		// unmapped address must leave endcap selected
		apb_write(SPARE_ADDR, 32'hffff_ffff);
		run_random(100, 0);
		drain();

		apb_write(BARREL_ADDR, 32'd1);
		run_random(100, 0);
		drain();

		apb_write(BARREL_ADDR, 32'hffff_fffe);
		run_random(100, 0);
		drain();
		repeat (8) @(posedge clk);

		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/pcc_pkg.sv
rtl/core/pcc_if.sv
rtl/core/pcc_apb_regs.sv
rtl/core/pcc_area_corr.sv
rtl/core/pcc_cut_eval.sv
rtl/core/photon_id_cut_classifier_core.sv
bench/tb_photon_id_cut_classifier_core.sv
